FILE: rtl/edge_dedup_hash_set_defines.svh
// ----------------------------------------------------------------------------
// Edge dedup hash set assertion macros
// Implication checks on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef EDGE_DEDUP_HASH_SET_DEFINES_SVH
`define EDGE_DEDUP_HASH_SET_DEFINES_SVH

// Same-cycle implication.
`define EDHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edge dedup hash set check failed");

// Next-cycle implication.
`define EDHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edge dedup hash set check failed");

`endif

FILE: rtl/edhs_pkg.sv
// ----------------------------------------------------------------------------
// Edge dedup hash set package
// Field widths, codes and controller state encoding.
// ----------------------------------------------------------------------------
package edhs_pkg;

  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned VTX_W     = 16;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned LG_W      = 4;
  localparam int unsigned MIX_SHIFT = 8;
  localparam logic [15:0] HASH_MULT = 16'd49157;
  localparam logic [LG_W-1:0] LG_RESET = 4'd10;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_NEW  = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_DONE = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HASH  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_CLEAR = 7'b0010000,
    S_INIT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

endpackage

FILE: rtl/edhs_ram.sv
// ----------------------------------------------------------------------------
// Edge dedup hash set RAM
// Single-port synchronous RAM, a write has priority and holds the read data, registered read.
// ----------------------------------------------------------------------------
module edhs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/edge_dedup_hash_set.sv
// ----------------------------------------------------------------------------
// Edge dedup hash set
// Open-addressing set of 32-bit mesh edge keys with linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one command beat: insert an
//   edge (vertex_a_i, vertex_b_i), read one slot (read_slot_i), or clear.
//   Output channel (out_valid_o/out_ready_i) returns one result beat per
//   command from an output register, so a new command is taken while the
//   previous result still waits.
//   An insert passes through the hash, read and compare steps, with one more
//   compare per extra probe (one table read per cycle); a read skips the
//   hash step; a clear zeroes one slot per cycle, then finishes in the done
//   step; an unknown op goes straight to the done step. The next command is
//   taken the cycle after the result is loaded, one command at a time.
//   The table size register (cfg_we_i/cfg_wdata_i) is to be written only while idle; the block does not enforce it.
//   After reset the block sweeps the whole table to zero with in_ready_o
//   low; config writes are taken during the sweep. When the receiver stalls
//   with a result held, a finished command waits in its last step (an
//   insert or read re-reading its slot) until the output register frees.
// ----------------------------------------------------------------------------
module edge_dedup_hash_set #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [edhs_pkg::LG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        op_i,
  input  logic [edhs_pkg::VTX_W-1:0]        vertex_a_i,
  input  logic [edhs_pkg::VTX_W-1:0]        vertex_b_i,
  input  logic [edhs_pkg::SLOT_W-1:0]       read_slot_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [edhs_pkg::SLOT_W-1:0]       slot_index_o,
  output logic [edhs_pkg::VTX_W-1:0]        edge_low_vertex_o,
  output logic [edhs_pkg::VTX_W-1:0]        edge_high_vertex_o,
  output logic                              occupied_o,
  output logic [1:0]                        status_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  edhs_pkg::state_e state_q, state_d;
  logic [edhs_pkg::LG_W-1:0]  lg_q;
  logic [edhs_pkg::KEY_W-1:0] key_q, key_d;
  logic [AW-1:0]              slot_q, slot_d;
  logic [AW-1:0]              cnt_q, cnt_d;
  logic                       rd_op_q, rd_op_d;

  logic                       out_valid_q, out_valid_d;
  logic [edhs_pkg::SLOT_W-1:0] out_slot_q;
  logic [edhs_pkg::KEY_W-1:0]  out_key_q;
  logic [1:0]                  out_status_q;

  logic [edhs_pkg::LG_W-1:0]  lg_eff;
  logic [AW-1:0]              mask;
  logic [edhs_pkg::KEY_W-1:0] mix;
  logic [AW-1:0]              hash;
  logic [edhs_pkg::VTX_W-1:0] v_lo, v_hi;
  logic [AW-1:0]              slot_next;

  logic                       mem_we;
  logic [AW-1:0]              mem_addr;
  logic [edhs_pkg::KEY_W-1:0] mem_wdata, mem_rdata;

  logic                       out_free, load_out, hit;
  logic [AW-1:0]              res_slot;
  logic [edhs_pkg::KEY_W-1:0] res_key;
  logic [1:0]                 res_status;

  edhs_ram #(
    .WIDTH(edhs_pkg::KEY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // Slot mask from the size register; sizes past the table saturate.
  assign lg_eff = (lg_q == '0) ? edhs_pkg::LG_W'(1) : lg_q;
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      mask[b] = (lg_eff > edhs_pkg::LG_W'(b));
    end
  end

  assign v_lo = (vertex_a_i < vertex_b_i) ? vertex_a_i : vertex_b_i;
  assign v_hi = (vertex_a_i < vertex_b_i) ? vertex_b_i : vertex_a_i;

  // Only the low AW bits of the product survive the mask.
  assign mix  = key_q + (key_q << edhs_pkg::MIX_SHIFT);
  assign hash = AW'(mix[AW-1:0] * AW'(edhs_pkg::HASH_MULT));

  assign slot_next = AW'(slot_q + 1'b1) & mask;
  assign hit = rd_op_q || (mem_rdata == '0) || (mem_rdata == key_q) || (cnt_q == mask);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == edhs_pkg::S_IDLE);

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    slot_d     = slot_q;
    cnt_d      = cnt_q;
    rd_op_d    = rd_op_q;
    mem_we     = 1'b0;
    mem_addr   = slot_q;
    mem_wdata  = key_q;
    load_out   = 1'b0;
    res_slot   = slot_q;
    res_key    = mem_rdata;
    res_status = edhs_pkg::ST_DONE;
    case (state_q)
      edhs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            edhs_pkg::OP_INSERT: begin
              key_d   = {v_lo, v_hi};
              rd_op_d = 1'b0;
              state_d = edhs_pkg::S_HASH;
            end
            edhs_pkg::OP_READ: begin
              slot_d  = AW'(read_slot_i) & mask;
              rd_op_d = 1'b1;
              state_d = edhs_pkg::S_RD;
            end
            edhs_pkg::OP_CLEAR: begin
              cnt_d   = '0;
              state_d = edhs_pkg::S_CLEAR;
            end
            default: begin
              state_d = edhs_pkg::S_DONE;
            end
          endcase
        end
      end
      edhs_pkg::S_HASH: begin
        slot_d  = hash & mask;
        cnt_d   = '0;
        state_d = edhs_pkg::S_RD;
      end
      edhs_pkg::S_RD: begin
        state_d = edhs_pkg::S_CMP;
      end
      edhs_pkg::S_CMP: begin
        if (hit) begin
          // Hold and re-read the same slot until the output register frees.
          if (out_free) begin
            load_out = 1'b1;
            state_d  = edhs_pkg::S_IDLE;
            if (!rd_op_q) begin
              mem_we  = 1'b1;
              res_key = key_q;
              if (mem_rdata == '0) begin
                res_status = edhs_pkg::ST_NEW;
              end else if (mem_rdata == key_q) begin
                res_status = edhs_pkg::ST_DUP;
              end else begin
                res_status = edhs_pkg::ST_FULL;
              end
            end
          end
        end else begin
          // Advance the probe; read the next slot ahead.
          slot_d   = slot_next;
          cnt_d    = AW'(cnt_q + 1'b1);
          mem_addr = slot_next;
        end
      end
      edhs_pkg::S_CLEAR, edhs_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = cnt_q;
        mem_wdata = '0;
        cnt_d     = AW'(cnt_q + 1'b1);
        if (cnt_q == LAST_SLOT) begin
          state_d = (state_q == edhs_pkg::S_CLEAR) ? edhs_pkg::S_DONE : edhs_pkg::S_IDLE;
        end
      end
      edhs_pkg::S_DONE: begin
        res_slot = '0;
        res_key  = '0;
        if (out_free) begin
          load_out = 1'b1;
          state_d  = edhs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = edhs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= edhs_pkg::S_INIT;
      cnt_q       <= '0;
      rd_op_q     <= 1'b0;
      lg_q        <= edhs_pkg::LG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_op_q     <= rd_op_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        lg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    slot_q <= slot_d;
    if (load_out) begin
      out_slot_q   <= edhs_pkg::SLOT_W'(res_slot);
      out_key_q    <= res_key;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign slot_index_o       = out_slot_q;
  assign edge_low_vertex_o  = out_key_q[edhs_pkg::KEY_W-1 -: edhs_pkg::VTX_W];
  assign edge_high_vertex_o = out_key_q[edhs_pkg::VTX_W-1:0];
  assign occupied_o         = (out_key_q != '0);
  assign status_o           = out_status_q;

endmodule

FILE: rtl/edhs_checker.sv
// ----------------------------------------------------------------------------
// Edge dedup hash set checker
// Port-level checks on the command and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "edge_dedup_hash_set_defines.svh"

module edhs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [edhs_pkg::SLOT_W-1:0] slot_index_o,
  input logic [edhs_pkg::VTX_W-1:0]  edge_low_vertex_o,
  input logic [edhs_pkg::VTX_W-1:0]  edge_high_vertex_o,
  input logic                        occupied_o,
  input logic [1:0]                  status_o
);

  // A stalled result beat holds.
  `EDHS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(slot_index_o) && $stable(status_o))

  // One command at a time: busy right after a beat is taken.
  `EDHS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o,
                    !in_ready_o)

  // Insert results carry an ordered key.
  `EDHS_ASSERT_IMP(a_key_order, clk_i, rst_ni,
                   out_valid_o && (status_o != edhs_pkg::ST_DONE),
                   edge_low_vertex_o <= edge_high_vertex_o)

  // A duplicate hit means the slot held a nonzero key.
  `EDHS_ASSERT_IMP(a_dup_occupied, clk_i, rst_ni,
                   out_valid_o && (status_o == edhs_pkg::ST_DUP), occupied_o)

endmodule

bind edge_dedup_hash_set edhs_checker u_edhs_checker (.*);

FILE: tb/sv/tb_edge_dedup_hash_set.sv
// ----------------------------------------------------------------------------
// Edge dedup hash set testbench
// Drives insert, read, clear and unknown commands through the valid/ready
// channels at several table sizes, keeps a shadow copy of the key table,
// and checks every result beat against it in order of arrival.
// ----------------------------------------------------------------------------
module tb_edge_dedup_hash_set;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned PHASE_ITEMS = 37;
  localparam int unsigned RUN_LIMIT   = 8_000_000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [1:0]  OP_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic [edhs_pkg::SLOT_W-1:0] slot;
    logic [edhs_pkg::VTX_W-1:0]  low_vtx;
    logic [edhs_pkg::VTX_W-1:0]  high_vtx;
    logic                        occupied;
    edhs_pkg::status_e           status;
  } edge_result_t;

  // Shadow of the key table plus the queue of result beats still owed.
  class edge_set_scoreboard;
    logic [edhs_pkg::KEY_W-1:0] key_table [TABLE_DEPTH];
    logic [edhs_pkg::LG_W-1:0]  size_lg;
    edge_result_t               owed_q[$];
    int unsigned                errors;

    function new();
      foreach (key_table[i]) key_table[i] = '0;
      size_lg = edhs_pkg::LG_RESET;
      errors  = 0;
    endfunction

    function void set_size(logic [edhs_pkg::LG_W-1:0] lg);
      size_lg = lg;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void note_cmd(logic [1:0] op, logic [edhs_pkg::VTX_W-1:0] va,
                           logic [edhs_pkg::VTX_W-1:0] vb,
                           logic [edhs_pkg::SLOT_W-1:0] rs);
      logic [edhs_pkg::LG_W-1:0]  lg;
      logic [31:0]                mask;
      logic [31:0]                hash;
      logic [edhs_pkg::KEY_W-1:0] key;
      logic [edhs_pkg::KEY_W-1:0] old_key;
      logic [edhs_pkg::VTX_W-1:0] lo;
      logic [edhs_pkg::VTX_W-1:0] hi;
      int unsigned                sz;
      int unsigned                step;
      int unsigned                slot;
      edge_result_t               r;
      lg = (size_lg == '0) ? 4'd1 : size_lg;
      sz = 1 << lg;
      if (sz > TABLE_DEPTH) sz = TABLE_DEPTH;
      mask = sz - 1;
      r = '0;
      r.status = edhs_pkg::ST_DONE;
      case (op)
        edhs_pkg::OP_INSERT: begin
          lo   = (va < vb) ? va : vb;
          hi   = (va < vb) ? vb : va;
          key  = {lo, hi};
          hash = (key + (key << edhs_pkg::MIX_SHIFT)) * edhs_pkg::HASH_MULT;
          step = 0;
          slot = hash & mask;
          // probe until an empty slot or the same key, at most mask steps
          while (step < mask) begin
            if (key_table[slot] == '0 || key_table[slot] == key) break;
            step++;
            slot = (hash + step) & mask;
          end
          old_key = key_table[slot];
          if (old_key == '0) r.status = edhs_pkg::ST_NEW;
          else if (old_key == key) r.status = edhs_pkg::ST_DUP;
          else r.status = edhs_pkg::ST_FULL;
          key_table[slot] = key;
          r.slot     = slot[edhs_pkg::SLOT_W-1:0];
          r.low_vtx  = key[31:16];
          r.high_vtx = key[15:0];
          r.occupied = (key != '0);
        end
        edhs_pkg::OP_READ: begin
          slot       = rs & mask;
          r.slot     = slot[edhs_pkg::SLOT_W-1:0];
          r.low_vtx  = key_table[slot][31:16];
          r.high_vtx = key_table[slot][15:0];
          r.occupied = (key_table[slot] != '0);
        end
        edhs_pkg::OP_CLEAR: begin
          foreach (key_table[i]) key_table[i] = '0;
        end
        default: begin
        end
      endcase
      owed_q.push_back(r);
    endfunction

    function void check_result(edge_result_t act);
      edge_result_t exp;
      if (owed_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("unexpected result beat: slot %0d low %h high %h occ %0d status %0d",
                   act.slot, act.low_vtx, act.high_vtx, act.occupied, act.status);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      if (act !== exp) begin
        if (errors < MAX_REPORTS) begin
          $display("mismatch: exp slot %0d low %h high %h occ %0d status %0d",
                   exp.slot, exp.low_vtx, exp.high_vtx, exp.occupied, exp.status);
          $display("          got slot %0d low %h high %h occ %0d status %0d",
                   act.slot, act.low_vtx, act.high_vtx, act.occupied, act.status);
        end
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [edhs_pkg::LG_W-1:0]   cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [1:0]                  op_i;
  logic [edhs_pkg::VTX_W-1:0]  vertex_a_i;
  logic [edhs_pkg::VTX_W-1:0]  vertex_b_i;
  logic [edhs_pkg::SLOT_W-1:0] read_slot_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [edhs_pkg::SLOT_W-1:0] slot_index_o;
  logic [edhs_pkg::VTX_W-1:0]  edge_low_vertex_o;
  logic [edhs_pkg::VTX_W-1:0]  edge_high_vertex_o;
  logic                        occupied_o;
  logic [1:0]                  status_o;

  edge_set_scoreboard sb = new();
  int unsigned        rx_park;
  int                 tx_calm;
  int unsigned        phase_items;

  edge_dedup_hash_set #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .vertex_a_i         (vertex_a_i),
    .vertex_b_i         (vertex_b_i),
    .read_slot_i        (read_slot_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .slot_index_o       (slot_index_o),
    .edge_low_vertex_o  (edge_low_vertex_o),
    .edge_high_vertex_o (edge_high_vertex_o),
    .occupied_o         (occupied_o),
    .status_o           (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Random gap before a beat, with occasional runs of back-to-back beats.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(8, 30);
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [edhs_pkg::VTX_W-1:0] pick_vertex(int unsigned pool);
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      1, 2:    return 16'($urandom);
      default: return 16'($urandom_range(0, pool));
    endcase
  endfunction

  task automatic send_cmd(logic [1:0] op, logic [edhs_pkg::VTX_W-1:0] va,
                          logic [edhs_pkg::VTX_W-1:0] vb,
                          logic [edhs_pkg::SLOT_W-1:0] rs);
    int gap;
    gap = draw_gap(tx_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    vertex_a_i  <= va;
    vertex_b_i  <= vb;
    read_slot_i <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_cmd(op, va, vb, rs);
    phase_items++;
  endtask

  task automatic do_insert(logic [edhs_pkg::VTX_W-1:0] va, logic [edhs_pkg::VTX_W-1:0] vb);
    send_cmd(edhs_pkg::OP_INSERT, va, vb, 10'($urandom));
  endtask

  task automatic do_read(logic [edhs_pkg::SLOT_W-1:0] rs);
    send_cmd(edhs_pkg::OP_READ, 16'($urandom), 16'($urandom), rs);
  endtask

  // Drop valid and hold until every owed result beat has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_size(logic [edhs_pkg::LG_W-1:0] lg);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lg;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_size(lg);
  endtask

  initial begin : result_sink
    int           gap;
    int           calm;
    edge_result_t act;
    calm        = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(calm);
      if (rx_park > 0) begin
        gap     = rx_park;
        rx_park = 0;
      end
      @(negedge clk_i);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      act.slot     = slot_index_o;
      act.low_vtx  = edge_low_vertex_o;
      act.high_vtx = edge_high_vertex_o;
      act.occupied = occupied_o;
      act.status   = edhs_pkg::status_e'(status_o);
      sb.check_result(act);
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [edhs_pkg::LG_W-1:0]  phase_lg [11];
    logic [edhs_pkg::LG_W-1:0]  lg;
    logic [edhs_pkg::VTX_W-1:0] va;
    logic [edhs_pkg::VTX_W-1:0] vb;
    logic [edhs_pkg::VTX_W-1:0] vc;
    int unsigned                sz;
    int unsigned                pool;
    int unsigned                pick;
    bit                         paused;
    phase_lg = '{4'd3, 4'd2, 4'd10, 4'd5, 4'd0, 4'd4, 4'd15, 4'd6, 4'd1, 4'd12, 4'd7};
    rx_park     = 0;
    tx_calm     = 0;
    phase_items = 0;
    paused      = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    op_i        = edhs_pkg::OP_INSERT;
    vertex_a_i  = '0;
    vertex_b_i  = '0;
    read_slot_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset size of 1024 slots.
    do_insert('0, '0);                // key of zero looks like an empty slot
    do_insert('1, '1);
    do_insert('1, '0);
    do_insert('0, '1);                // same edge, other orientation
    do_insert(16'h1234, 16'hABCD);
    do_insert(16'hABCD, 16'h1234);
    do_insert(16'h8001, 16'h7FFE);
    do_read('0);
    do_read('1);
    do_read(10'd512);
    send_cmd(OP_UNKNOWN, '1, '1, '1);
    send_cmd(edhs_pkg::OP_CLEAR, '1, '1, '1);
    do_read('1);
    do_insert(16'h1234, 16'hABCD);    // new again after the clear
    wait_idle();
    write_size(4'd1);
    do_insert(16'd1, 16'd2);
    do_insert(16'd3, 16'd4);
    do_insert(16'd6, 16'd5);          // both slots taken: overwrite
    do_read('0);
    do_read('1);                      // wraps to the size in use
    wait_idle();
    write_size(4'd0);                 // zero counts as two slots
    do_insert(16'd7, 16'd8);
    do_read(10'd2);
    wait_idle();
    write_size(4'd15);                // saturates at the full depth
    do_insert(16'hABCD, 16'h1234);
    do_read('1);

    foreach (phase_lg[ph]) begin
      wait_idle();
      write_size(phase_lg[ph]);
      lg = (phase_lg[ph] == '0) ? 4'd1 : phase_lg[ph];
      sz = (lg >= 4'd10) ? TABLE_DEPTH : (1 << lg);
      pool = $urandom_range(4, 64);
      phase_items = 0;
      // park the receiver so the block backs up and stalls its input
      if (ph == 2) rx_park = 150;
      while (phase_items < PHASE_ITEMS) begin
        if (ph == 5 && !paused && phase_items >= 20) begin
          paused = 1'b1;
          wait_idle();
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          va = pick_vertex(pool);
          vb = pick_vertex(pool);
          vc = pick_vertex(pool);
          do_insert(va, vb);
          do_insert(vc, vb);
          do_insert(va, vc);
        end else if (pick < 62) begin
          do_insert(16'($urandom), 16'($urandom));
        end else if (pick < 72) begin
          if (sz <= 32) begin
            for (int s = 0; s < sz; s++) do_read(10'(s));
          end else begin
            repeat (8) do_read(10'($urandom));
          end
        end else if (pick < 86) begin
          do_read(10'($urandom));
        end else if (pick < 91) begin
          send_cmd(OP_UNKNOWN, 16'($urandom), 16'($urandom), 10'($urandom));
        end else if (pick < 94) begin
          send_cmd(edhs_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 10'($urandom));
        end else begin
          va = pick_vertex(pool);
          do_insert(va, va);
        end
      end
    end

    wait_idle();
    repeat (64) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/edhs_pkg.sv
rtl/edhs_ram.sv
rtl/edge_dedup_hash_set.sv
rtl/edhs_checker.sv
tb/sv/tb_edge_dedup_hash_set.sv
